[rtl/core/hars_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hars_pkg
// Shared types and constants for the health-aware round-robin selector.
// ----------------------------------------------------------------------------
package hars_pkg;

    localparam int MAX_TARGETS = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DIRECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROXIES      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SELF  = 3'd6;

    localparam logic [1:0] MODE_FIXED   = 2'd0;
    localparam logic [1:0] MODE_ROTATE  = 2'd1;
    localparam logic [1:0] MODE_HASH    = 2'd2;
    localparam logic [1:0] MODE_LATCHED = 2'd3;

    localparam logic [1:0] OUT_CHOSEN  = 2'd0;
    localparam logic [1:0] OUT_DIRECT  = 2'd1;
    localparam logic [1:0] OUT_FAIL    = 2'd2;
    localparam logic [1:0] OUT_WRITTEN = 2'd3;

    localparam logic [1:0] HOST_UP        = 2'd0;
    localparam logic [1:0] HOST_SELF_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  action_unused;
        logic        action;
        logic        first_try;
        logic        client_known;
        logic [31:0] client_hash;
        logic [3:0]  prior_start;
        logic [3:0]  prior_pick;
        logic        wrapped_before;
        logic [31:0] now_time;
        logic [3:0]  entry_index;
        logic [31:0] entry_fail_time;
        logic [15:0] entry_fail_count;
        logic [1:0]  entry_host_state;
    } req_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [3:0] chosen_index;
        logic [3:0] start_index;
        logic       is_retry;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  start_mode;
        logic [4:0]  target_count;
        logic [15:0] fail_limit;
        logic [15:0] retry_delay;
        logic        allow_direct;
        logic        targets_are_proxies;
        logic        ignore_self_down;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, set up
        logic write;     // table write
        logic mod_start; // begin modulo
        logic mod_step;  // one restoring-division step
        logic set_start; // start/cur from modulo result or fixed
        logic retry_set; // start/cur from prior fields
        logic scan_step; // examine cur, advance
        logic emit_hit;
        logic emit_bypass;
        logic emit_written;
        logic out_pop;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_write;
        logic empty;
        logic first;
        logic need_mod;  // start derivation needs modulo
        logic retry_wrap;
        logic hit;       // cur entry usable
        logic scan_end;  // after advance, scan over
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/hars_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hars_req_if / hars_rsp_if
// Valid/ready channels carrying request and result transfers.
// ----------------------------------------------------------------------------
interface hars_req_if;
    import hars_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hars_rsp_if;
    import hars_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/health_aware_round_robin_selector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// health_aware_round_robin_selector
// Picks a healthy upstream target per request; update transfers write the table.
// ----------------------------------------------------------------------------
// Sequence: a write is decoded and answered from the result register; a select
// runs decode, the serial modulo (rotate, hash with client, latched, every
// retry), set-up, a wrap check on a retry, then a scan of up to 16 entries.
// One transfer at a time; a new request is taken once the result register
// is empty. Reset: rst_n asynchronous active low; clears FSM, counters and the
// health table, and returns the config registers to their defaults.
module health_aware_round_robin_selector
    import hars_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    hars_req_if.sink                   req,
    hars_rsp_if.source                 rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{start_mode: 2'd0, target_count: 5'd0, fail_limit: 16'd10,
                         retry_delay: 16'd300, allow_direct: 1'b0,
                         targets_are_proxies: 1'b1, ignore_self_down: 1'b0};
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_MODE:   cfg_reg.start_mode          <= cfg_data[1:0];
                REG_TARGET_COUNT: cfg_reg.target_count        <= cfg_data[4:0];
                REG_FAIL_LIMIT:   cfg_reg.fail_limit          <= cfg_data;
                REG_RETRY_DELAY:  cfg_reg.retry_delay         <= cfg_data;
                REG_ALLOW_DIRECT: cfg_reg.allow_direct        <= cfg_data[0];
                REG_PROXIES:      cfg_reg.targets_are_proxies <= cfg_data[0];
                REG_IGNORE_SELF:  cfg_reg.ignore_self_down    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    hars_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hars_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req.data),
        .cmd       (cmd),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_data  (rsp.data),
        .sts       (sts)
    );

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_hit, cmd.emit_bypass, cmd.emit_written}))
        else $error("multiple result sources");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("accept while result pending");

    a_hit_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_hit |=> rsp.valid && rsp.data.outcome == OUT_CHOSEN)
        else $error("hit not reported");

endmodule

`default_nettype wire

[rtl/core/hars_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hars_datapath
// Health table, start index derivation (serial modulo), scan and result reg.
// ----------------------------------------------------------------------------
module hars_datapath
    import hars_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire req_t req,
    input  wire cmd_t cmd,
    input  wire logic out_ready,
    output logic      out_valid,
    output rsp_t      out_data,
    output sts_t      sts
);

    logic [31:0] ft_reg [MAX_TARGETS];
    logic [15:0] fc_reg [MAX_TARGETS];
    logic [1:0]  hs_reg [MAX_TARGETS];

    req_t        req_reg;
    logic [4:0]  n_reg;
    logic [31:0] rot_reg;
    logic [3:0]  latch_reg;
    logic [3:0]  start_reg;
    logic [3:0]  cur_reg;
    logic [4:0]  step_reg;
    logic [31:0] dvd_reg;
    logic [4:0]  rem_reg;
    logic        out_valid_reg;
    rsp_t        out_reg;

    logic [4:0]  n_eff;
    logic [31:0] swapped;
    logic [5:0]  rem_shift;
    logic [5:0]  rem_sub;
    logic [3:0]  cur_inc;
    logic [3:0]  retry_cur;
    logic [1:0]  hs_cur;
    logic        up;
    logic [32:0] deadline;
    logic        plain_ok;
    logic        retry_ok;
    logic [1:0]  byp;

    assign n_eff = (cfg.target_count > CNT_W'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS)
                                                            : cfg.target_count;
    assign swapped = {req_reg.client_hash[7:0], req_reg.client_hash[15:8],
                      req_reg.client_hash[23:16], req_reg.client_hash[31:24]};

    assign rem_shift = {rem_reg, dvd_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, n_reg};

    function automatic logic [3:0] wrap_inc(input logic [3:0] v, input logic [4:0] n);
        logic [4:0] s;
        s = {1'b0, v} + 5'd1;
        wrap_inc = (s >= n) ? 4'd0 : s[3:0];
    endfunction

    // (prior_pick + 1) % n comes from the serial modulo
    assign cur_inc   = wrap_inc(cur_reg, n_reg);
    assign retry_cur = rem_reg[3:0];

    assign hs_cur   = hs_reg[cur_reg];
    assign up       = (hs_cur == HOST_UP) || (hs_cur == HOST_SELF_DOWN && cfg.ignore_self_down);
    assign deadline = {1'b0, ft_reg[cur_reg]} + {17'd0, cfg.retry_delay};
    assign plain_ok = (ft_reg[cur_reg] == 32'd0) || (fc_reg[cur_reg] < cfg.fail_limit);
    assign retry_ok = req_reg.wrapped_before || (deadline < {1'b0, req_reg.now_time});
    assign byp      = (cfg.allow_direct && cfg.targets_are_proxies) ? OUT_DIRECT : OUT_FAIL;

    always_comb
    begin
        sts.is_write   = req_reg.action;
        sts.empty      = (n_reg == 5'd0);
        sts.first      = req_reg.first_try;
        sts.need_mod   = (cfg.start_mode == MODE_ROTATE) ||
                         (cfg.start_mode == MODE_LATCHED) ||
                         (cfg.start_mode == MODE_HASH && req_reg.client_known);
        sts.retry_wrap = (retry_cur == req_reg.prior_start) && cfg.allow_direct;
        sts.hit        = up && (plain_ok || retry_ok);
        sts.scan_end   = (cur_inc == start_reg) || ((step_reg + 5'd1) == n_reg);
        sts.out_full   = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_TARGETS; i++) begin
                ft_reg[i] <= '0;
                fc_reg[i] <= '0;
                hs_reg[i] <= HOST_UP;
            end
        end else if (cmd.write) begin
            ft_reg[req_reg.entry_index] <= req_reg.entry_fail_time;
            fc_reg[req_reg.entry_index] <= req_reg.entry_fail_count;
            hs_reg[req_reg.entry_index] <= req_reg.entry_host_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rot_reg       <= '0;
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.mod_start && req_reg.first_try && cfg.start_mode == MODE_ROTATE) begin
                rot_reg <= rot_reg + 32'd1;
            end
            if (cmd.retry_set) begin
                latch_reg <= retry_cur;
            end
            if (cmd.scan_step) begin
                latch_reg <= cur_inc;
            end
            if (cmd.emit_hit || cmd.emit_bypass || cmd.emit_written) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            req_reg <= req;
            n_reg   <= n_eff;
        end
        if (cmd.mod_start) begin
            rem_reg <= '0;
            if (!req_reg.first_try) begin
                dvd_reg <= {27'd0, {1'b0, req_reg.prior_pick} + 5'd1};
            end else begin
                unique case (cfg.start_mode)
                    MODE_ROTATE:  dvd_reg <= rot_reg;
                    MODE_HASH:    dvd_reg <= swapped;
                    default:      dvd_reg <= {28'd0, latch_reg};
                endcase
            end
        end
        if (cmd.mod_step) begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_sub[5] ? rem_shift[4:0] : rem_sub[4:0];
        end
        if (cmd.set_start) begin
            start_reg <= sts.need_mod ? rem_reg[3:0] : 4'd0;
            cur_reg   <= sts.need_mod ? rem_reg[3:0] : 4'd0;
            step_reg  <= '0;
        end
        if (cmd.retry_set) begin
            start_reg <= req_reg.prior_start;
            cur_reg   <= retry_cur;
            step_reg  <= '0;
        end
        if (cmd.scan_step) begin
            cur_reg  <= cur_inc;
            step_reg <= step_reg + 5'd1;
        end
        if (cmd.emit_hit) begin
            out_reg.outcome      <= OUT_CHOSEN;
            out_reg.chosen_index <= cur_reg;
            out_reg.start_index  <= start_reg;
            out_reg.is_retry     <= !plain_ok;
        end
        if (cmd.emit_bypass) begin
            out_reg.outcome      <= byp;
            out_reg.chosen_index <= '0;
            out_reg.start_index  <= (sts.empty && req_reg.first_try) ? 4'd0
                                  : (sts.empty ? req_reg.prior_start : start_reg);
            out_reg.is_retry     <= 1'b0;
        end
        if (cmd.emit_written) begin
            out_reg.outcome      <= OUT_WRITTEN;
            out_reg.chosen_index <= '0;
            out_reg.start_index  <= '0;
            out_reg.is_retry     <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic unused_swap;
    assign unused_swap = cmd.out_pop ^ ^req_reg.action_unused;

endmodule

`default_nettype wire

[rtl/core/hars_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hars_ctrl
// Sequencer: decode, start derivation, scan, result hand-off.
// ----------------------------------------------------------------------------
module hars_ctrl
    import hars_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_SET   = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_RETRY = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_full;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_write) begin
                    cmd.write        = 1'b1;
                    cmd.emit_written = 1'b1;
                    state_next       = S_IDLE;
                end else if (sts.empty) begin
                    cmd.emit_bypass = 1'b1;
                    state_next      = S_IDLE;
                end else if (!sts.first || sts.need_mod) begin
                    cmd.mod_start = 1'b1;
                    cnt_next      = 6'd32;
                    state_next    = S_MOD;
                end else begin
                    state_next = S_SET;
                end
            end
            S_RETRY:
            begin
                if (sts.retry_wrap) begin
                    cmd.emit_bypass = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_SET;
                end
            end
            S_SET:
            begin
                if (sts.first) begin
                    cmd.set_start = 1'b1;
                    state_next    = S_SCAN;
                end else begin
                    cmd.retry_set = 1'b1;
                    state_next    = S_RETRY;
                end
            end
            S_SCAN:
            begin
                if (sts.hit) begin
                    cmd.emit_hit = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_end) begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                cmd.emit_bypass = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[tb/health_aware_round_robin_selector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// health_aware_round_robin_selector_test
// Self-checking bench for the target selector. Directed transfers with fixed
// results cover table writes and empty-table answers; each start mode and random
// phases (set or random register settings) follow, checked against a local model
// of the health table, the rotating counter and the latched index.
// ----------------------------------------------------------------------------
module health_aware_round_robin_selector_test;
    import hars_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int RANDOM_ITEMS = 1600;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hars_req_if req ();
    hars_rsp_if rsp ();

    health_aware_round_robin_selector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic [1:0]  m_mode;
    logic [4:0]  m_count;
    logic [15:0] m_limit;
    logic [15:0] m_delay;
    logic        m_direct;
    logic        m_proxies;
    logic        m_ignore_self;
    logic [31:0] m_fail_time [MAX_TARGETS];
    logic [15:0] m_fail_count [MAX_TARGETS];
    logic [1:0]  m_host [MAX_TARGETS];
    logic [31:0] m_rotate;
    logic [3:0]  m_latched;

    rsp_t pending_picks [$];
    row_t rows [$];
    int   errors = 0;
    int   cycles = 0;
    int   n_results = 0;
    int   n_writes = 0;
    int   n_selects = 0;
    bit   calm = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t timeout, %0d results outstanding", $time, pending_picks.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [1:0] bypass_outcome();
        return (m_direct && m_proxies) ? OUT_DIRECT : OUT_FAIL;
    endfunction

    function automatic rsp_t predict_pick(req_t r);
        rsp_t        o;
        int          n;
        int          cur;
        int          start;
        logic [31:0] h;
        logic [1:0]  hs;
        logic        up;
        o = '0;
        if (r.action)
        begin
            m_fail_time[r.entry_index]  = r.entry_fail_time;
            m_fail_count[r.entry_index] = r.entry_fail_count;
            m_host[r.entry_index]       = r.entry_host_state;
            o.outcome = OUT_WRITTEN;
            return o;
        end
        n = (m_count > MAX_TARGETS) ? MAX_TARGETS : int'(m_count);
        if (n == 0)
        begin
            o.outcome     = bypass_outcome();
            o.start_index = r.first_try ? 4'd0 : r.prior_start;
            return o;
        end
        if (r.first_try)
        begin
            case (m_mode)
                MODE_FIXED:  start = 0;
                MODE_ROTATE:
                begin
                    start    = int'(m_rotate % n);
                    m_rotate = m_rotate + 1;
                end
                MODE_HASH:
                begin
                    h = r.client_hash;
                    h = {h[7:0], h[15:8], h[23:16], h[31:24]};
                    start = r.client_known ? int'(h % n) : 0;
                end
                default: start = int'(m_latched) % n;
            endcase
            cur = start;
        end
        else
        begin
            start     = int'(r.prior_start);
            cur       = (int'(r.prior_pick) + 1) % n;
            m_latched = cur[3:0];
            if (cur == start && m_direct)
            begin
                o.outcome     = bypass_outcome();
                o.start_index = start[3:0];
                return o;
            end
        end
        o.start_index = start[3:0];
        o.outcome     = bypass_outcome();
        for (int step = 0; step < n; step++)
        begin
            hs = m_host[cur];
            up = (hs == HOST_UP) || (hs == HOST_SELF_DOWN && m_ignore_self);
            if (up)
            begin
                if (m_fail_time[cur] == 0 || m_fail_count[cur] < m_limit)
                begin
                    o.outcome      = OUT_CHOSEN;
                    o.chosen_index = cur[3:0];
                    return o;
                end
                if (r.wrapped_before ||
                    ({1'b0, m_fail_time[cur]} + 33'(m_delay)) < {1'b0, r.now_time})
                begin
                    o.outcome      = OUT_CHOSEN;
                    o.chosen_index = cur[3:0];
                    o.is_retry     = 1'b1;
                    return o;
                end
            end
            cur       = (cur + 1) % n;
            m_latched = cur[3:0];
            if (cur == start)
                break;
        end
        return o;
    endfunction

    function automatic req_t make_write(int idx, logic [31:0] ft, logic [15:0] cnt,
                                        logic [1:0] hs);
        req_t r;
        r = '0;
        r.action           = 1'b1;
        r.entry_index      = idx[3:0];
        r.entry_fail_time  = ft;
        r.entry_fail_count = cnt;
        r.entry_host_state = hs;
        r.client_hash      = $urandom();
        r.now_time         = $urandom();
        return r;
    endfunction

    function automatic req_t make_select(bit first, bit known, logic [31:0] hash,
                                         int ps, int pp, bit wrapped, logic [31:0] now);
        req_t r;
        r = '0;
        r.first_try      = first;
        r.client_known   = known;
        r.client_hash    = hash;
        r.prior_start    = ps[3:0];
        r.prior_pick     = pp[3:0];
        r.wrapped_before = wrapped;
        r.now_time       = now;
        r.entry_index    = 4'($urandom());
        r.entry_fail_time = $urandom();
        return r;
    endfunction

    function automatic void add_row(req_t r, bit typed, rsp_t want);
        row_t w;
        w.item  = r;
        w.typed = typed;
        w.want  = want;
        rows.push_back(w);
    endfunction

    task automatic send_item(req_t r, bit typed, rsp_t want);
        int   gap;
        rsp_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.data  <= r;
        req.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        pred = predict_pick(r);
        pending_picks.push_back(typed ? want : pred);
        if (r.action)
            n_writes++;
        else
            n_selects++;
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_MODE:   m_mode        = value[1:0];
            REG_TARGET_COUNT: m_count       = value[4:0];
            REG_FAIL_LIMIT:   m_limit       = value;
            REG_RETRY_DELAY:  m_delay       = value;
            REG_ALLOW_DIRECT: m_direct      = value[0];
            REG_PROXIES:      m_proxies     = value[0];
            default:          m_ignore_self = value[0];
        endcase
    endtask

    task automatic set_all(int mode, int count, int lim, int dly, bit ad, bit px, bit is);
        write_reg(REG_START_MODE, 16'(mode));
        write_reg(REG_TARGET_COUNT, 16'(count));
        write_reg(REG_FAIL_LIMIT, 16'(lim));
        write_reg(REG_RETRY_DELAY, 16'(dly));
        write_reg(REG_ALLOW_DIRECT, 16'(ad));
        write_reg(REG_PROXIES, 16'(px));
        write_reg(REG_IGNORE_SELF, 16'(is));
    endtask

    function automatic req_t random_item(int n_hint);
        int          ps;
        int          pp;
        logic [31:0] ft;
        if ($urandom_range(0, 3) == 0)
        begin
            ft = ($urandom_range(0, 3) == 0) ? 32'd0 :
                 ($urandom_range(0, 1) ? 32'($urandom_range(1, 2000)) : $urandom());
            return make_write($urandom_range(0, 15), ft,
                              $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom()),
                              2'($urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3)));
        end
        pp = (n_hint > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, n_hint - 1)
                                                      : $urandom_range(0, 15);
        ps = (n_hint > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, n_hint - 1)
                                                      : $urandom_range(0, 15);
        return make_select(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, $urandom(),
                           ps, pp, $urandom_range(0, 3) == 0,
                           $urandom_range(0, 1) ? 32'($urandom_range(0, 70000)) : $urandom());
    endfunction

    // result side: random stalls, check at rising edge
    initial
    begin
        int stall;
        stall = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (!calm)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            n_results++;
            if (pending_picks.size() == 0)
            begin
                $display("%0t unexpected result transfer %p", $time, rsp.data);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (rsp.data.outcome !== want.outcome)
                begin
                    $display("%0t outcome: expected %0d actual %0d", $time,
                             want.outcome, rsp.data.outcome);
                    errors++;
                end
                if (rsp.data.chosen_index !== want.chosen_index)
                begin
                    $display("%0t chosen_index: expected %0d actual %0d", $time,
                             want.chosen_index, rsp.data.chosen_index);
                    errors++;
                end
                if (rsp.data.start_index !== want.start_index)
                begin
                    $display("%0t start_index: expected %0d actual %0d", $time,
                             want.start_index, rsp.data.start_index);
                    errors++;
                end
                if (rsp.data.is_retry !== want.is_retry)
                begin
                    $display("%0t is_retry: expected %0d actual %0d", $time,
                             want.is_retry, rsp.data.is_retry);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rsp_t none;
        rsp_t w;
        int   n_hint;
        req.valid = 1'b0;
        req.data  = '0;
        m_mode = MODE_FIXED; m_count = 0; m_limit = 16'd10; m_delay = 16'd300;
        m_direct = 1'b0; m_proxies = 1'b1; m_ignore_self = 1'b0;
        m_rotate = '0; m_latched = '0;
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            m_fail_time[i] = '0; m_fail_count[i] = '0; m_host[i] = HOST_UP;
        end
        none = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: no table, bypass not allowed -> fail
        w = none; w.outcome = OUT_FAIL;
        add_row(make_select(1, 1, 32'hFFFF_FFFF, 15, 15, 1, 32'hFFFF_FFFF), 1, w);
        w.start_index = 4'd15;
        add_row(make_select(0, 0, 32'h0, 15, 0, 0, 32'h0), 1, w);
        w = none; w.outcome = OUT_WRITTEN;
        for (int i = 0; i < MAX_TARGETS; i++)
            add_row(make_write(i, (i % 3 == 0) ? 32'd0 : 32'(i * 100),
                               (i == 15) ? 16'hFFFF : 16'(i * 2),
                               (i == 15) ? 2'd3 : 2'(i % 3)), 1, w);
        foreach (rows[k])
            send_item(rows[k].item, rows[k].typed, rows[k].want);
        drain();

        // full table, each start mode and the retry corner cases
        for (int mode = 0; mode < 4; mode++)
        begin
            set_all(mode, 16, 10, 300, 1, 1, mode[0]);
            send_item(make_select(1, 1, 32'h1234_5678, 0, 0, 0, 32'd50), 0, none);
            send_item(make_select(1, 0, 32'hDEAD_BEEF, 0, 0, 0, 32'd5000), 0, none);
            send_item(make_select(0, 1, 32'h0, 4, 3, 0, 32'd5000), 0, none);
            send_item(make_select(0, 1, 32'h0, 15, 14, 1, 32'hFFFF_FFFF), 0, none);
            drain();
        end

        for (int phase = 0; phase < 14; phase++)
        begin
            calm = (phase % 5 == 4);
            case (phase)
                0: set_all(MODE_ROTATE, 1, 0, 0, 0, 0, 0);
                1: set_all(MODE_HASH, 31, 65535, 65535, 1, 0, 1);
                2: set_all(MODE_LATCHED, 0, 10, 300, 1, 1, 0);
                3: set_all(MODE_FIXED, 16, 1, 65535, 1, 1, 1);
                default: set_all($urandom_range(0, 3), $urandom_range(0, 9) < 7 ?
                                 $urandom_range(1, 16) : $urandom_range(0, 31),
                                 $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 65535),
                                 $urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom_range(0, 65535),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
            endcase
            n_hint = (m_count > MAX_TARGETS) ? MAX_TARGETS : int'(m_count);
            for (int k = 0; k < RANDOM_ITEMS / 14; k++)
                send_item(random_item(n_hint), 0, none);
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d selects and %0d table writes, %0d results checked,",
                 n_selects, n_writes, n_results);
        $display("over all four start modes and register extremes; %0d mismatches.", errors);
        if (errors == 0 && pending_picks.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hars_pkg.sv
rtl/core/hars_if.sv
rtl/core/hars_datapath.sv
rtl/core/hars_ctrl.sv
rtl/core/health_aware_round_robin_selector.sv
tb/health_aware_round_robin_selector_test.sv
